// ----- rtl/sha256_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, sequencer states and round helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumWords = 8;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned PadLimit = 56;
  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StLoad,
    StRound,
    StFinal,
    StOut
  } state_e;

  localparam word_t InitHash [NumWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (WordW - n));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sha256_core.sv -----
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round per cycle while round_i is high, over a 16-word rolling message schedule.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_core (
  input  wire logic                   clk_i,
  input  wire logic                   load_i,   // take chaining value and block
  input  wire logic                   round_i,  // run one round
  input  wire logic [5:0]             round_idx_i,
  input  wire sha256_pkg::word_t      hin_i  [8],
  input  wire sha256_pkg::word_t      blk_i  [16],
  output      sha256_pkg::word_t      v_o    [8]
);
  import sha256_pkg::*;

  word_t v_q [8];
  word_t w_q [16];
  word_t s0, s1, wnew, big1, big0, ch, maj, t1;

  always_comb begin
    s0   = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
    s1   = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0 + w_q[9] + s1;
    big1 = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1   = v_q[7] + big1 + ch + RoundK[round_idx_i] + w_q[0];
    big0 = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
    maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      v_q <= hin_i;
      w_q <= blk_i;
    end else if (round_i) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + big0 + maj;
    end
  end

  assign v_o = v_q;

endmodule

`default_nettype wire

// ----- rtl/sha256_byte_stream_hasher_top.sv -----
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Gathers message bytes into blocks, compresses them and emits the digest.
// ----------------------------------------------------------------------------
// A request whose byte does not complete a block leaves the input ready; a byte
// that completes one blocks the input while the block is loaded, run through
// 64 rounds in the single round unit and folded into the hash state.
// An end mark adds the padding bytes, written one at a time (the length goes in
// alongside byte 55), one or two such compressions and eight output requests. Reset
// (asynchronous, active low) restores the initial hash and clears fill and count.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_byte_stream_hasher_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // tdata: [7:0] message_byte
  input  wire logic [7:0]  s_axis_tdata,
  // tuser: [0] byte_present
  input  wire logic        s_axis_tuser,
  // tlast: message_end
  input  wire logic        s_axis_tlast,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: [31:0] digest_word, [34:32] word_number, [39:35] zero
  output      logic [39:0] m_axis_tdata,
  // tlast: last_word
  output      logic        m_axis_tlast
);
  import sha256_pkg::*;

  state_e state_q, state_d;

  // The block buffer holds sixteen big-endian words; each byte lands in its
  // lane by position, and entries are only read after being written.
  word_t       buf_q [16];
  word_t       hash_q [8];
  logic [5:0]  fill_q;
  logic [63:0] count_q;
  logic [63:0] bit_len;
  logic        end_q;       // message end pending after this compression
  logic        len_done_q;  // final (length) block has been filled
  logic        pad_first_q; // the 0x80 byte is still to be written
  logic [5:0]  rnd_q;
  logic [2:0]  out_idx_q;

  word_t v [8];
  logic  load, round;

  // Message length in bits, modulo 2^64.
  assign bit_len = {count_q[60:0], 3'b000};

  sha256_core u_core (
    .clk_i       (clk_i),
    .load_i      (load),
    .round_i     (round),
    .round_idx_i (rnd_q),
    .hin_i       (hash_q),
    .blk_i       (buf_q),
    .v_o         (v)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser && fill_q == 6'd63) state_d = StLoad;
          else if (s_axis_tlast) state_d = StPad;
        end
      end
      StPad: begin
        // The block is ready at byte 55 with the length, or at byte 63.
        if (fill_q == 6'd63 || fill_q == 6'd55) state_d = StLoad;
      end
      StLoad:  state_d = StRound;
      StRound: if (rnd_q == 6'd63) state_d = StFinal;
      StFinal: begin
        if (!end_q) state_d = StIdle;
        else if (len_done_q) state_d = StOut;
        else state_d = StPad;
      end
      StOut: if (m_axis_tready && out_idx_q == 3'd7) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Output and control decode.
  always_comb begin
    s_axis_tready = 1'b0;
    load          = 1'b0;
    round         = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state_q)
      StIdle:  s_axis_tready = 1'b1;
      StLoad:  load = 1'b1;
      StRound: round = 1'b1;
      StOut:   m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign m_axis_tdata = {5'd0, out_idx_q, hash_q[out_idx_q]};
  assign m_axis_tlast = (out_idx_q == 3'd7);

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  // Buffer writes: incoming bytes, pad bytes and the length field.
  always_ff @(posedge clk_i) begin
    if (acc && s_axis_tuser) buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= s_axis_tdata;
    if (state_q == StPad) begin
      if (fill_q == 6'd55) begin
        buf_q[14] <= bit_len[63:32];
        buf_q[15] <= bit_len[31:0];
      end
      buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= pad_first_q ? PadByte : 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      hash_q      <= InitHash;
      fill_q      <= '0;
      count_q     <= '0;
      end_q       <= 1'b0;
      len_done_q  <= 1'b0;
      pad_first_q <= 1'b0;
      rnd_q       <= '0;
      out_idx_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          if (acc) begin
            if (s_axis_tuser) begin
              fill_q  <= fill_q + 6'd1;
              count_q <= count_q + 64'd1;
            end
            end_q       <= s_axis_tlast;
            pad_first_q <= s_axis_tlast;
            len_done_q  <= 1'b0;
          end
        end
        StPad: begin
          pad_first_q <= 1'b0;
          if (fill_q == 6'd55 || fill_q == 6'd63) begin
            len_done_q <= (fill_q == 6'd55);
            fill_q     <= '0;
          end else begin
            fill_q <= fill_q + 6'd1;
          end
        end
        StLoad:  rnd_q <= '0;
        StRound: rnd_q <= rnd_q + 6'd1;
        StFinal: begin
          for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v[i];
          out_idx_q <= '0;
        end
        StOut: begin
          if (m_axis_tready) begin
            out_idx_q <= out_idx_q + 3'd1;
            if (out_idx_q == 3'd7) begin
              hash_q  <= InitHash;
              fill_q  <= '0;
              count_q <= '0;
              end_q   <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // The round counter only advances while rounds are running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StRound && state_q != StLoad) |=> $stable(rnd_q) || $past(state_q) == StLoad)
    else $error("round counter moved outside compression");

  // No input is taken while a digest is being delivered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted during digest output");

  // After the last digest word the hash state is back at the initial values (checked on word 0).
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> hash_q[0] == InitHash[0])
    else $error("hash state not restored after digest");

endmodule

`default_nettype wire

// ----- dv/sha256_byte_stream_hasher_top_tb.sv -----
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Streams messages byte by byte into the hasher and checks every digest word
// against a SHA-256 calculation kept alongside the stream, under varied
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module sha256_byte_stream_hasher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sha256_pkg::*;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
  } digest_res_t;

  localparam int unsigned TimeoutCycles = 2000000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  sha256_byte_stream_hasher_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Shadow of the hashing state, updated as each request is accepted.
  word_t       hash_state [NumWords];
  logic [7:0]  pending_block [BlockBytes];
  int unsigned pending_fill;
  logic [63:0] bytes_hashed;

  digest_res_t expected_words [$];
  int unsigned error_count;
  int unsigned requests_sent;
  int unsigned digests_seen;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  longint unsigned cycle_count;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic word_t rot_right(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Runs the 64 rounds over the pending block and folds them into the state.
  function automatic void compress_pending();
    word_t sched [64];
    word_t v [8];
    word_t s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) begin
      sched[t] = {pending_block[4*t], pending_block[4*t+1],
                  pending_block[4*t+2], pending_block[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      s0 = rot_right(sched[t-15], 7) ^ rot_right(sched[t-15], 18) ^ (sched[t-15] >> 3);
      s1 = rot_right(sched[t-2], 17) ^ rot_right(sched[t-2], 19) ^ (sched[t-2] >> 10);
      sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
    end
    for (int t = 0; t < 8; t++) v[t] = hash_state[t];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + sched[t];
      t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int t = 0; t < 8; t++) hash_state[t] += v[t];
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < NumWords; i++) hash_state[i] = InitHash[i];
    pending_fill = 0;
    bytes_hashed = '0;
  endfunction

  // Applies one accepted request and queues any digest words it produces.
  function automatic void predict_request(input logic present, input logic [7:0] data,
                                          input logic end_mark);
    logic [63:0] bit_len;
    digest_res_t res;
    if (present) begin
      pending_block[pending_fill] = data;
      pending_fill++;
      bytes_hashed++;
      if (pending_fill == BlockBytes) begin
        compress_pending();
        pending_fill = 0;
      end
    end
    if (!end_mark) return;
    bit_len = bytes_hashed << 3;
    pending_block[pending_fill] = PadByte;
    pending_fill++;
    if (pending_fill > PadLimit) begin
      while (pending_fill < BlockBytes) begin
        pending_block[pending_fill] = 8'h00;
        pending_fill++;
      end
      compress_pending();
      pending_fill = 0;
    end
    while (pending_fill < PadLimit) begin
      pending_block[pending_fill] = 8'h00;
      pending_fill++;
    end
    for (int i = 0; i < 8; i++) pending_block[PadLimit + i] = bit_len[63 - 8*i -: 8];
    compress_pending();
    for (int i = 0; i < NumWords; i++) begin
      res.digest_word = hash_state[i];
      res.word_number = 3'(i);
      res.last_word   = (i == NumWords - 1);
      expected_words  = {expected_words, res};
    end
    restart_message();
  endfunction

  // Drives one request, holding it until the hasher accepts it.
  task automatic send_request(input logic present, input logic [7:0] data,
                              input logic end_mark);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = present;
    s_axis_tdata  = data;
    s_axis_tlast  = end_mark;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_request(present, data, end_mark);
    requests_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = 1'b0;
    s_axis_tdata  = 8'($urandom);
    s_axis_tlast  = 1'b0;
  endtask

  task automatic send_message(input int unsigned n_bytes);
    for (int i = 0; i < n_bytes; i++) begin
      // Empty requests scattered through the message must be ignored.
      if ($urandom_range(9) == 0) send_request(1'b0, 8'($urandom), 1'b0);
      if (i == n_bytes - 1 && $urandom_range(1)) send_request(1'b1, 8'($urandom), 1'b1);
      else begin
        send_request(1'b1, 8'($urandom), 1'b0);
        if (i == n_bytes - 1) send_request(1'b0, 8'($urandom), 1'b1);
      end
    end
    if (n_bytes == 0) send_request(1'b0, 8'($urandom), 1'b1);
  endtask

  task automatic wait_drained();
    while (expected_words.size() != 0) @(negedge clk_i);
  endtask

  // Known vectors; the padding boundaries at 55, 56 and 64 bytes follow in test_pad_boundaries.
  task automatic test_directed();
    send_request(1'b0, 8'hff, 1'b0);
    send_request(1'b0, 8'h00, 1'b1);                  // empty message
    send_request(1'b1, 8'h61, 1'b0);                  // "abc"
    send_request(1'b1, 8'h62, 1'b0);
    send_request(1'b1, 8'h63, 1'b1);
    send_request(1'b1, 8'h00, 1'b1);                  // lone zero byte with end mark
    send_request(1'b1, 8'hff, 1'b0);
    send_request(1'b0, 8'h5a, 1'b0);
    send_request(1'b1, 8'hff, 1'b1);
    wait_drained();
  endtask

  task automatic test_pad_boundaries();
    int unsigned sizes [3] = '{55, 56, 64};
    foreach (sizes[i]) send_message(sizes[i]);
    wait_drained();
  endtask

  task automatic test_random_messages(input int unsigned n_requests);
    int unsigned start;
    start = requests_sent;
    while (requests_sent - start < n_requests) begin
      if ($urandom_range(9) == 0) send_message($urandom_range(56, 72));
      else send_message($urandom_range(0, 12));
    end
    wait_drained();
  endtask

  // Checks each digest word as it is accepted.
  always @(posedge clk_i) begin
    digest_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata[31:0], '0);
      end else begin
        want = expected_words.pop_front();
        if (m_axis_tdata[31:0] != want.digest_word)
          report_mismatch("digest_word", m_axis_tdata[31:0], want.digest_word);
        if (m_axis_tdata[34:32] != want.word_number)
          report_mismatch("word_number", 32'(m_axis_tdata[34:32]), 32'(want.word_number));
        if (m_axis_tdata[39:35] != '0)
          report_mismatch("tdata pad bits", 32'(m_axis_tdata[39:35]), '0);
        if (m_axis_tlast != want.last_word)
          report_mismatch("last_word", 32'(m_axis_tlast), 32'(want.last_word));
        if (want.last_word) digests_seen++;
      end
    end
  end

  // Receiver back-pressure, changed on the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > TimeoutCycles) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("sha256_byte_stream_hasher_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned idle_sets [4][2] = '{'{0, 0}, '{48, 0}, '{0, 48}, '{35, 35}};
    error_count    = 0;
    requests_sent  = 0;
    digests_seen   = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    s_axis_tlast   = 1'b0;
    m_axis_tready  = 1'b0;
    restart_message();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_pad_boundaries();
    // One phase per idling pattern.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_sets[p][0];
      recv_stall_pct = idle_sets[p][1];
      test_random_messages(25);
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (200) @(negedge clk_i);

    $display("Sent %0d requests and checked %0d digests", requests_sent, digests_seen);
    $display("Covered empty, padding-boundary and multi-block messages under stalls");
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("sha256_byte_stream_hasher_top_tb OK");
    end else begin
      $display("sha256_byte_stream_hasher_top_tb NOT OK");
    end
    $finish;
  end

endmodule
